// ===== src/fcs_pkg.sv =====
package fcs_pkg;

	localparam int FW     = 24;   // position, velocity and force fields
	localparam int CFG_W  = 23;   // widest configuration register
	localparam int CFG_IW = 2;    // configuration register index
	localparam int RT_W   = 25;   // square root result width
	localparam int PROD_W = 50;   // squared offset width

	localparam logic [CFG_IW-1:0] REG_MEMBER_COUNT = 2'd0;
	localparam logic [CFG_IW-1:0] REG_RADIUS       = 2'd1;
	localparam logic [CFG_IW-1:0] REG_TOP_SPEED    = 2'd2;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_QRD,
		ST_QLAT,
		ST_WALK,
		ST_DRAIN,
		ST_DXS,
		ST_DXW,
		ST_DYS,
		ST_DYW,
		ST_MSQ,
		ST_MSUM,
		ST_RTS,
		ST_RTW,
		ST_SCL,
		ST_QXS,
		ST_QXW,
		ST_QYS,
		ST_QYW,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		DSEL_AVGX,
		DSEL_AVGY,
		DSEL_SCLX,
		DSEL_SCLY
	} div_sel_t;

	typedef struct packed {
		logic     load_we;
		logic     rd_en;
		logic     q_lat;
		logic     issue;
		logic     skip;
		logic     clr_acc;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_cap;
		logic     msq;
		logic     msum;
		logic     rt_start;
		logic     scl;
		logic     fin;
		logic     bad;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic div_done;
		logic rt_done;
		logic cnt_zero;
		logic mag_zero;
		logic out_free;
	} status_t;

endpackage

// ===== src/fcs_divider.sv =====
module fcs_divider #(
	parameter int DW = 48,
	parameter int VW = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DW);
			done_q <= 1'b0;
		end else begin
			done_q <= cnt_q == CW'(1);
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== src/fcs_isqrt.sv =====
module fcs_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [2*fcs_pkg::RT_W-1:0]     radicand,
	output logic [fcs_pkg::RT_W-1:0]       root,
	output logic                           done
);

	localparam int RW = fcs_pkg::RT_W;
	localparam int CW = $clog2(RW + 1);

	logic [2*RW-1:0] rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            done_q;
	logic [RW+3:0]   rem_n;
	logic [RW+3:0]   trial;
	logic            ge;

	// two radicand bits per step
	always_comb begin
		rem_n = {rem_q, rad_q[2*RW-1:2*RW-2]};
		trial = (RW+4)'({root_q, 2'b01});
		ge    = rem_n >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(RW);
			done_q <= 1'b0;
		end else begin
			done_q <= cnt_q == CW'(1);
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[2*RW-3:0], 2'b00};
			rem_q  <= ge ? (RW+2)'(rem_n - trial) : rem_n[RW+1:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ===== src/fcs_datapath.sv =====
module fcs_datapath #(
	parameter int MAX_MEMBERS = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fcs_pkg::cmd_t                      cmd,
	input  logic [$clog2(MAX_MEMBERS)-1:0]     rd_addr,
	input  logic [7:0]                         member_index,
	input  logic signed [fcs_pkg::FW-1:0]      pos_x,
	input  logic signed [fcs_pkg::FW-1:0]      pos_y,
	input  logic signed [fcs_pkg::FW-1:0]      vel_x,
	input  logic signed [fcs_pkg::FW-1:0]      vel_y,
	input  logic [fcs_pkg::CFG_W-1:0]          neighbour_radius,
	input  logic [fcs_pkg::CFG_W-1:0]          top_speed,
	input  logic                               out_ready,
	output fcs_pkg::status_t                   sts,
	output logic                               out_valid,
	output logic signed [fcs_pkg::FW-1:0]      force_x,
	output logic signed [fcs_pkg::FW-1:0]      force_y,
	output logic [7:0]                         neighbour_total,
	output logic                               bad_index
);

	localparam int AW = $clog2(MAX_MEMBERS);
	localparam int SW = 26 + AW;
	localparam int DW = (SW > 48) ? SW : 48;
	localparam int VW = (AW > 25) ? AW : 25;
	localparam int FW = fcs_pkg::FW;
	localparam int PW = fcs_pkg::PROD_W;
	localparam int RW = fcs_pkg::RT_W;

	function automatic logic signed [FW-1:0] sat24(input logic signed [FW+1:0] v);
		logic signed [FW+1:0] hi;
		logic signed [FW+1:0] lo;
		hi = (FW+2)'((1 << (FW-1)) - 1);
		lo = -(FW+2)'(1 << (FW-1));
		if (v > hi) begin
			return hi[FW-1:0];
		end else if (v < lo) begin
			return lo[FW-1:0];
		end
		return v[FW-1:0];
	endfunction

	logic [4*FW-1:0] mem [MAX_MEMBERS];
	logic [4*FW-1:0] rdata_q;

	logic signed [FW-1:0] rd_px;
	logic signed [FW-1:0] rd_py;
	logic signed [FW-1:0] qpx_q;
	logic signed [FW-1:0] qpy_q;
	logic signed [FW-1:0] qvx_q;
	logic signed [FW-1:0] qvy_q;
	logic [2*fcs_pkg::CFG_W-1:0] rsq_q;

	logic                 v_s1;
	logic                 v_s2;
	logic                 v_s3;
	logic signed [FW:0]   dx_s2;
	logic signed [FW:0]   dy_s2;
	logic signed [FW:0]   dx_s3;
	logic signed [FW:0]   dy_s3;
	logic signed [PW-1:0] sqx_s3;
	logic signed [PW-1:0] sqy_s3;
	logic [PW:0]          d2;
	logic                 hit;

	logic [AW-1:0]        cnt_q;
	logic signed [SW-1:0] sx_q;
	logic signed [SW-1:0] sy_q;
	logic signed [FW:0]   ax_q;
	logic signed [FW:0]   ay_q;
	logic signed [PW-1:0] mx_q;
	logic signed [PW-1:0] my_q;
	logic [PW-1:0]        m2_q;
	logic signed [2*FW:0] prx_q;
	logic signed [2*FW:0] pry_q;
	logic signed [FW:0]   qx_q;
	logic signed [FW:0]   qy_q;

	logic [SW-1:0]        sx_abs;
	logic [SW-1:0]        sy_abs;
	logic [2*FW:0]        prx_abs;
	logic [2*FW:0]        pry_abs;
	logic [DW-1:0]        dvd;
	logic [VW-1:0]        dvs;
	logic                 dsgn;
	logic [DW-1:0]        quo;
	logic signed [FW:0]   qsig;
	logic                 div_done;
	logic [RW-1:0]        root;
	logic                 rt_done;

	logic                 out_valid_q;
	logic signed [FW-1:0] fx_q;
	logic signed [FW-1:0] fy_q;
	logic [7:0]           tot_q;
	logic                 bad_q;
	logic signed [FW+1:0] rfx;
	logic signed [FW+1:0] rfy;
	logic [7:0]           tot;

	// member store: one write port for loads, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load_we && (32'(member_index) < MAX_MEMBERS)) begin
			mem[AW'(member_index)] <= {vel_y, vel_x, pos_y, pos_x};
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rd_px = rdata_q[FW-1:0];
	assign rd_py = rdata_q[2*FW-1:FW];

	always_ff @(posedge clk) begin
		rsq_q <= neighbour_radius * neighbour_radius;
		if (cmd.q_lat) begin
			qpx_q <= rdata_q[FW-1:0];
			qpy_q <= rdata_q[2*FW-1:FW];
			qvx_q <= rdata_q[3*FW-1:2*FW];
			qvy_q <= rdata_q[4*FW-1:3*FW];
		end
	end

	// neighbour walk pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue && !cmd.skip;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= {rd_px[FW-1], rd_px} - {qpx_q[FW-1], qpx_q};
		dy_s2  <= {rd_py[FW-1], rd_py} - {qpy_q[FW-1], qpy_q};
		dx_s3  <= dx_s2;
		dy_s3  <= dy_s2;
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
	end

	assign d2  = {1'b0, unsigned'(sqx_s3)} + {1'b0, unsigned'(sqy_s3)};
	assign hit = d2 < (PW+1)'(rsq_q);

	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
		end else if (v_s3 && hit) begin
			cnt_q <= cnt_q + AW'(1);
			sx_q  <= sx_q + {{(SW-FW-1){dx_s3[FW]}}, dx_s3};
			sy_q  <= sy_q + {{(SW-FW-1){dy_s3[FW]}}, dy_s3};
		end
	end

	// shared divider operand selection
	always_comb begin
		sx_abs  = sx_q[SW-1] ? unsigned'(-sx_q) : unsigned'(sx_q);
		sy_abs  = sy_q[SW-1] ? unsigned'(-sy_q) : unsigned'(sy_q);
		prx_abs = prx_q[2*FW] ? unsigned'(-prx_q) : unsigned'(prx_q);
		pry_abs = pry_q[2*FW] ? unsigned'(-pry_q) : unsigned'(pry_q);
		unique case (cmd.div_sel)
			fcs_pkg::DSEL_AVGX: begin
				dvd  = DW'(sx_abs);
				dvs  = VW'(cnt_q);
				dsgn = sx_q[SW-1];
			end
			fcs_pkg::DSEL_AVGY: begin
				dvd  = DW'(sy_abs);
				dvs  = VW'(cnt_q);
				dsgn = sy_q[SW-1];
			end
			fcs_pkg::DSEL_SCLX: begin
				dvd  = DW'(prx_abs[2*FW-1:0]);
				dvs  = VW'(root);
				dsgn = prx_q[2*FW];
			end
			fcs_pkg::DSEL_SCLY: begin
				dvd  = DW'(pry_abs[2*FW-1:0]);
				dvs  = VW'(root);
				dsgn = pry_q[2*FW];
			end
			default: begin
				dvd  = '0;
				dvs  = '0;
				dsgn = 1'b0;
			end
		endcase
		qsig = dsgn ? -signed'(quo[FW:0]) : signed'(quo[FW:0]);
	end

	fcs_divider #(
		.DW (DW),
		.VW (VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo),
		.done     (div_done)
	);

	fcs_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.rt_start),
		.radicand (m2_q),
		.root     (root),
		.done     (rt_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_cap) begin
			unique case (cmd.div_sel)
				fcs_pkg::DSEL_AVGX: ax_q <= qsig;
				fcs_pkg::DSEL_AVGY: ay_q <= qsig;
				fcs_pkg::DSEL_SCLX: qx_q <= qsig;
				fcs_pkg::DSEL_SCLY: qy_q <= qsig;
				default: ;
			endcase
		end
		if (cmd.msq) begin
			mx_q <= ax_q * ax_q;
			my_q <= ay_q * ay_q;
		end
		if (cmd.msum) begin
			m2_q <= unsigned'(mx_q + my_q);
		end
		if (cmd.scl) begin
			prx_q <= ax_q * signed'({1'b0, top_speed});
			pry_q <= ay_q * signed'({1'b0, top_speed});
		end
	end

	// final steering and saturation
	always_comb begin
		if (root == '0) begin
			rfx = -(FW+2)'(qvx_q);
			rfy = -(FW+2)'(qvy_q);
		end else begin
			rfx = (FW+2)'(qx_q) - (FW+2)'(qvx_q);
			rfy = (FW+2)'(qy_q) - (FW+2)'(qvy_q);
		end
		tot = (32'(cnt_q) > 255) ? 8'hFF : 8'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			bad_q <= cmd.bad;
			if (cmd.bad || cnt_q == '0) begin
				fx_q  <= '0;
				fy_q  <= '0;
				tot_q <= '0;
			end else begin
				fx_q  <= sat24(rfx);
				fy_q  <= sat24(rfy);
				tot_q <= tot;
			end
		end
	end

	assign sts.pipe_busy = v_s1 || v_s2 || v_s3;
	assign sts.div_done  = div_done;
	assign sts.rt_done   = rt_done;
	assign sts.cnt_zero  = cnt_q == '0;
	assign sts.mag_zero  = root == '0;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign force_x         = fx_q;
	assign force_y         = fy_q;
	assign neighbour_total = tot_q;
	assign bad_index       = bad_q;

endmodule

// ===== src/fcs_ctrl.sv =====
module fcs_ctrl #(
	parameter int MAX_MEMBERS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                kind,
	input  logic [7:0]                          member_index,
	input  logic [$clog2(MAX_MEMBERS+1)-1:0]    active,
	input  fcs_pkg::status_t                    sts,
	output logic                                in_ready,
	output fcs_pkg::cmd_t                       cmd,
	output logic [$clog2(MAX_MEMBERS)-1:0]      rd_addr
);

	localparam int AW  = $clog2(MAX_MEMBERS);
	localparam int ACW = $clog2(MAX_MEMBERS + 1);

	fcs_pkg::state_t state_q;
	fcs_pkg::state_t state_d;
	logic [AW-1:0]   walk_q;
	logic [AW-1:0]   qidx_q;
	logic            bad_q;
	logic            query_acc;
	logic            idx_bad;
	logic            walk_last;

	assign query_acc = (state_q == fcs_pkg::ST_IDLE) && in_valid && (kind == fcs_pkg::KIND_QUERY);
	assign idx_bad   = 32'(member_index) >= 32'(active);
	assign walk_last = (ACW'(walk_q) + ACW'(1)) == active;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fcs_pkg::ST_IDLE:  if (query_acc) state_d = idx_bad ? fcs_pkg::ST_FIN : fcs_pkg::ST_QRD;
			fcs_pkg::ST_QRD:   state_d = fcs_pkg::ST_QLAT;
			fcs_pkg::ST_QLAT:  state_d = fcs_pkg::ST_WALK;
			fcs_pkg::ST_WALK:  if (walk_last) state_d = fcs_pkg::ST_DRAIN;
			fcs_pkg::ST_DRAIN: begin
				if (!sts.pipe_busy) state_d = sts.cnt_zero ? fcs_pkg::ST_FIN : fcs_pkg::ST_DXS;
			end
			fcs_pkg::ST_DXS:   state_d = fcs_pkg::ST_DXW;
			fcs_pkg::ST_DXW:   if (sts.div_done) state_d = fcs_pkg::ST_DYS;
			fcs_pkg::ST_DYS:   state_d = fcs_pkg::ST_DYW;
			fcs_pkg::ST_DYW:   if (sts.div_done) state_d = fcs_pkg::ST_MSQ;
			fcs_pkg::ST_MSQ:   state_d = fcs_pkg::ST_MSUM;
			fcs_pkg::ST_MSUM:  state_d = fcs_pkg::ST_RTS;
			fcs_pkg::ST_RTS:   state_d = fcs_pkg::ST_RTW;
			fcs_pkg::ST_RTW: begin
				if (sts.rt_done) state_d = sts.mag_zero ? fcs_pkg::ST_FIN : fcs_pkg::ST_SCL;
			end
			fcs_pkg::ST_SCL:   state_d = fcs_pkg::ST_QXS;
			fcs_pkg::ST_QXS:   state_d = fcs_pkg::ST_QXW;
			fcs_pkg::ST_QXW:   if (sts.div_done) state_d = fcs_pkg::ST_QYS;
			fcs_pkg::ST_QYS:   state_d = fcs_pkg::ST_QYW;
			fcs_pkg::ST_QYW:   if (sts.div_done) state_d = fcs_pkg::ST_FIN;
			fcs_pkg::ST_FIN:   if (sts.out_free) state_d = fcs_pkg::ST_IDLE;
			default:           state_d = fcs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.div_sel = fcs_pkg::DSEL_AVGX;
		in_ready    = state_q == fcs_pkg::ST_IDLE;
		rd_addr     = (state_q == fcs_pkg::ST_QRD) ? qidx_q : walk_q;
		cmd.load_we = in_ready && in_valid && (kind == fcs_pkg::KIND_LOAD);
		cmd.rd_en   = (state_q == fcs_pkg::ST_QRD) || (state_q == fcs_pkg::ST_WALK);
		cmd.q_lat   = state_q == fcs_pkg::ST_QLAT;
		cmd.issue   = state_q == fcs_pkg::ST_WALK;
		cmd.skip    = walk_q == qidx_q;
		cmd.clr_acc = state_q == fcs_pkg::ST_QRD;
		cmd.msq     = state_q == fcs_pkg::ST_MSQ;
		cmd.msum    = state_q == fcs_pkg::ST_MSUM;
		cmd.rt_start = state_q == fcs_pkg::ST_RTS;
		cmd.scl     = state_q == fcs_pkg::ST_SCL;
		cmd.fin     = (state_q == fcs_pkg::ST_FIN) && sts.out_free;
		cmd.bad     = bad_q;
		unique case (state_q)
			fcs_pkg::ST_DXS, fcs_pkg::ST_DXW: cmd.div_sel = fcs_pkg::DSEL_AVGX;
			fcs_pkg::ST_DYS, fcs_pkg::ST_DYW: cmd.div_sel = fcs_pkg::DSEL_AVGY;
			fcs_pkg::ST_QXS, fcs_pkg::ST_QXW: cmd.div_sel = fcs_pkg::DSEL_SCLX;
			fcs_pkg::ST_QYS, fcs_pkg::ST_QYW: cmd.div_sel = fcs_pkg::DSEL_SCLY;
			default:                          cmd.div_sel = fcs_pkg::DSEL_AVGX;
		endcase
		cmd.div_start = (state_q == fcs_pkg::ST_DXS) || (state_q == fcs_pkg::ST_DYS)
			|| (state_q == fcs_pkg::ST_QXS) || (state_q == fcs_pkg::ST_QYS);
		cmd.div_cap = sts.div_done && ((state_q == fcs_pkg::ST_DXW)
			|| (state_q == fcs_pkg::ST_DYW) || (state_q == fcs_pkg::ST_QXW)
			|| (state_q == fcs_pkg::ST_QYW));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcs_pkg::ST_IDLE;
			walk_q  <= '0;
			qidx_q  <= '0;
			bad_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (query_acc) begin
				qidx_q <= AW'(member_index);
				bad_q  <= idx_bad;
			end
			if (state_q == fcs_pkg::ST_QRD) begin
				walk_q <= '0;
			end else if (state_q == fcs_pkg::ST_WALK) begin
				walk_q <= walk_q + AW'(1);
			end
		end
	end

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fcs_pkg::ST_WALK |-> ACW'(walk_q) < active)
		else $error("walk address beyond active member count");

	a_bad_goes_fin: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc && idx_bad |=> state_q == fcs_pkg::ST_FIN && bad_q)
		else $error("bad query index did not go straight to result");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == fcs_pkg::ST_DXW || state_q == fcs_pkg::ST_DYW
			|| state_q == fcs_pkg::ST_QXW || state_q == fcs_pkg::ST_QYW))
		else $error("divider finished outside a wait state");

	a_rt_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.rt_done |-> state_q == fcs_pkg::ST_RTW)
		else $error("square root finished outside its wait state");

	a_no_issue_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fcs_pkg::ST_DRAIN && !sts.pipe_busy |=> !sts.pipe_busy)
		else $error("walk pipeline refilled after drain");

endmodule

// ===== src/flock_cohesion_steering_top.sv =====
// Load request: accepted while idle, no result.
// Query request over N active members: a serial store walk, one member a cycle,
// then, given any hits, up to four 48-step divisions and a 25-step root.
// Bad query index: straight to the result state, no walk. Throughput
// is one request at a time; a finished result waits in the output register.
// arst_n clears config, state and handshakes; store and data registers are not.
module flock_cohesion_steering_top #(
	parameter int MAX_MEMBERS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [103:0]                  s_tdata,   // member_index, pos_x, pos_y, vel_x, vel_y
	input  logic                          s_tuser,   // kind
	// result channel
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [55:0]                   m_tdata,   // force_x, force_y, neighbour_total
	output logic                          m_tuser,   // bad_index
	// configuration writes
	input  logic                          cfg_we,
	input  logic [fcs_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [fcs_pkg::CFG_W-1:0]     cfg_data
);

	localparam int AW  = $clog2(MAX_MEMBERS);
	localparam int ACW = $clog2(MAX_MEMBERS + 1);
	localparam int FW  = fcs_pkg::FW;

	logic [8:0]                    member_count_q;
	logic [fcs_pkg::CFG_W-1:0]     radius_q;
	logic [fcs_pkg::CFG_W-1:0]     top_speed_q;
	logic [ACW-1:0]                active;

	fcs_pkg::cmd_t                 cmd;
	fcs_pkg::status_t              sts;
	logic [AW-1:0]                 rd_addr;

	logic signed [FW-1:0]          force_x;
	logic signed [FW-1:0]          force_y;
	logic [7:0]                    neighbour_total;

	// Hold configuration; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_count_q <= '0;
			radius_q       <= '0;
			top_speed_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcs_pkg::REG_MEMBER_COUNT: member_count_q <= cfg_data[8:0];
				fcs_pkg::REG_RADIUS:       radius_q       <= cfg_data;
				fcs_pkg::REG_TOP_SPEED:    top_speed_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the member count to the store capacity.
	assign active = (32'(member_count_q) > MAX_MEMBERS) ? ACW'(MAX_MEMBERS)
		: ACW'(member_count_q);

	fcs_ctrl #(
		.MAX_MEMBERS (MAX_MEMBERS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.kind         (s_tuser),
		.member_index (s_tdata[7:0]),
		.active       (active),
		.sts          (sts),
		.in_ready     (s_tready),
		.cmd          (cmd),
		.rd_addr      (rd_addr)
	);

	fcs_datapath #(
		.MAX_MEMBERS (MAX_MEMBERS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.rd_addr          (rd_addr),
		.member_index     (s_tdata[7:0]),
		.pos_x            (s_tdata[31:8]),
		.pos_y            (s_tdata[55:32]),
		.vel_x            (s_tdata[79:56]),
		.vel_y            (s_tdata[103:80]),
		.neighbour_radius (radius_q),
		.top_speed        (top_speed_q),
		.out_ready        (m_tready),
		.sts              (sts),
		.out_valid        (m_tvalid),
		.force_x          (force_x),
		.force_y          (force_y),
		.neighbour_total  (neighbour_total),
		.bad_index        (m_tuser)
	);

	// Pack the result fields, lowest first.
	assign m_tdata = {neighbour_total, force_y, force_x};

endmodule
